// File: hdl/sdsi_pkg.sv
`default_nettype none
package sdsi_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAG_BITS   = VALUE_BITS - 1;
    localparam int SUM_BITS   = MAG_BITS + 4;
    localparam int OUT_BITS   = 64;
    localparam int CHAR_BITS  = 8;
    localparam int M_DATA_W   = 72;

    localparam logic [MAG_BITS-1:0]  MAX_MAG = {MAG_BITS{1'b1}};

    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_FAIL   = 2'd2
    } phase_t;

    typedef struct packed {
        logic                 valid;
        logic [CHAR_BITS-1:0] ch;
    } char_beat_t;

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage
`default_nettype wire

// File: hdl/strict_decimal_string_to_int.sv
// Strict decimal string to signed integer.
// Slave stream: one character per transaction in s_axis_tdata; a zero byte
// terminates the string. Leading whitespace, one optional sign, then one or
// more decimal digits; anything else marks the string invalid.
// Master stream: one transaction per terminator; bit 0 is the valid flag,
// bits 64:1 the signed value (zero when invalid). Magnitudes above
// 2^(VALUE_BITS-1)-1 are invalid.
// Throughput: one character per cycle, except while a terminator is held
// back by a stalled master; the multiply-by-ten, add and limit compare sit
// combinationally between the input register and the parser state.
// A terminator passes through the input register and then the result
// register before its result is presented on the master stream.
// A stalled master only holds back a terminator that finds the result
// register full; digits and whitespace keep flowing in the meantime.
// Reset clears the parser to the leading-whitespace state and drops any
// pending character and result.
`default_nettype none
module strict_decimal_string_to_int (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] character
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [sdsi_pkg::M_DATA_W-1:0]      m_axis_tdata   // [0] valid_res, [64:1] value
);
    import sdsi_pkg::*;

    char_beat_t          beat;
    logic                advance;
    logic                res_ok;
    logic [OUT_BITS-1:0] res_value;

    sdsi_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .advance  (advance),
        .beat     (beat)
    );

    sdsi_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_ok    (res_ok),
        .out_value (res_value)
    );

    assign m_axis_tdata = {{(M_DATA_W-OUT_BITS-1){1'b0}}, res_value, res_ok};

endmodule
`default_nettype wire

// File: hdl/sdsi_in_stage.sv
`default_nettype none
module sdsi_in_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sdsi_pkg::CHAR_BITS-1:0] in_char,
    input  wire logic                          advance,
    output sdsi_pkg::char_beat_t               beat
);
    import sdsi_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [CHAR_BITS-1:0] char_reg;
    logic [CHAR_BITS-1:0] char_next;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            char_next  = in_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign beat.valid = valid_reg;
    assign beat.ch    = char_reg;

endmodule
`default_nettype wire

// File: hdl/sdsi_parse.sv
`default_nettype none
module sdsi_parse (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sdsi_pkg::char_beat_t        beat,
    output logic                             advance,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_ok,
    output logic [sdsi_pkg::OUT_BITS-1:0]    out_value
);
    import sdsi_pkg::*;

    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [MAG_BITS-1:0] mag_reg, mag_next;
    logic                seen_reg, seen_next;
    logic                oval_reg, oval_next;
    logic                ok_reg, ok_next;
    logic [OUT_BITS-1:0] value_reg, value_next;

    logic                is_term;
    logic                take_digit;
    logic [SUM_BITS-1:0] mag_wide;
    logic [SUM_BITS-1:0] sum;
    logic                overflow;
    logic [OUT_BITS-1:0] mag_ext;

    assign is_term  = (beat.ch == CH_NUL);
    assign advance  = beat.valid && (!is_term || !oval_reg || out_ready);
    assign mag_wide = {4'b0, mag_reg};
    assign sum      = (mag_wide << 3) + (mag_wide << 1)
                      + {{(SUM_BITS-4){1'b0}}, 4'(beat.ch - CH_ZERO)};
    assign overflow = (sum > {4'b0, MAX_MAG});
    assign mag_ext  = {{(OUT_BITS-MAG_BITS){1'b0}}, mag_reg};

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        seen_next  = seen_reg;
        oval_next  = oval_reg && !out_ready;
        ok_next    = ok_reg;
        value_next = value_reg;
        take_digit = 1'b0;

        if (advance)
        begin
            if (is_term)
            begin
                oval_next  = 1'b1;
                ok_next    = (phase_reg == PH_DIGITS) && seen_reg;
                value_next = '0;
                if ((phase_reg == PH_DIGITS) && seen_reg)
                begin
                    value_next = neg_reg ? (OUT_BITS'(0) - mag_ext) : mag_ext;
                end
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                mag_next   = '0;
                seen_next  = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space(beat.ch))
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if ((beat.ch == CH_MINUS) || (beat.ch == CH_PLUS))
                        begin
                            neg_next   = (beat.ch == CH_MINUS);
                            phase_next = PH_DIGITS;
                        end
                        else if (is_digit(beat.ch))
                        begin
                            take_digit = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit(beat.ch))
                        begin
                            take_digit = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                if (take_digit)
                begin
                    if (overflow)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                        mag_next   = sum[MAG_BITS-1:0];
                        seen_next  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            seen_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            seen_reg  <= seen_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        value_reg <= value_next;
    end

    assign out_valid = oval_reg;
    assign out_ok    = ok_reg;
    assign out_value = value_reg;

endmodule
`default_nettype wire
